// File: sv/pde_pkg.sv
// Shared types, constants and helpers for the projectile drag Euler stepper.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package pde_pkg;

    typedef logic signed [47:0] t_q24;

    localparam t_q24 MAX48       = 48'sh7FFF_FFFF_FFFF;
    localparam t_q24 MIN48       = 48'sh8000_0000_0000;
    localparam t_q24 GRAV_Q24    = 48'sd164584325;
    localparam t_q24 PI_Q24      = 48'sd52707179;
    localparam t_q24 HALF_PI_Q24 = 48'sd26353589;
    localparam t_q24 TWO_PI_Q24  = 48'sd105414357;
    localparam t_q24 CORDIC_GAIN = 48'sd10188014;

    localparam logic [31:0] TIME_STEP_RST = 32'd858993;
    localparam logic [31:0] DRAG_RST      = 32'd1609317;
    localparam t_q24        STOP_X_RST    = 48'sd167772160000;
    localparam t_q24        STOP_Y_RST    = 48'sd0;

    typedef enum logic [1:0] {
        CFG_TIME_STEP,
        CFG_DRAG_COEFF,
        CFG_STOP_X,
        CFG_STOP_Y
    } t_cfg_idx;

    typedef enum logic {
        OP_LAUNCH,
        OP_STEP
    } t_opcode;

    typedef struct packed {
        logic [31:0] time_step;
        logic [31:0] drag_coeff;
        t_q24        stop_x;
        t_q24        stop_y;
    } t_cfg;

    typedef struct packed {
        logic opcode;
        t_q24 launch_speed;
        t_q24 launch_angle;
        t_q24 launch_x;
        t_q24 launch_y;
    } t_in;

    typedef struct packed {
        logic [63:0] elapsed_time;
        t_q24        speed;
        t_q24        heading;
        t_q24        pos_x;
        t_q24        pos_y;
        logic        finished;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_FOLD,
        S_CORDIC,
        S_MUL_GO,
        S_MUL_WAIT,
        S_SUM,
        S_DIV_GO,
        S_DIV,
        S_DIV_END,
        S_FINISH,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LAUNCH,
        DP_MOD_INIT,
        DP_MOD_RUN,
        DP_FOLD,
        DP_CORDIC,
        DP_MUL_START,
        DP_MUL_WAIT,
        DP_DRAG_SUM,
        DP_DIV_START,
        DP_DIV_RUN,
        DP_DIV_END,
        DP_FINISH
    } t_dp_op;

    // order matters: the controller walks it by increment
    typedef enum logic [3:0] {
        MS_V2,
        MS_GSN,
        MS_V2D,
        MS_GCS,
        MS_VCS,
        MS_VSN,
        MS_DVDT,
        MS_DADT,
        MS_DXDT,
        MS_DYDT
    } t_mul_sel;

    typedef struct packed {
        t_dp_op   op;
        t_mul_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_flight;
        logic mod_last;
        logic cordic_last;
        logic mul_done;
        logic div_last;
    } t_dp_stat;

    function automatic logic [47:0] mag48(input t_q24 v);
        logic [47:0] u;
        u = v;
        return v[47] ? (~u + 48'd1) : u;
    endfunction

    function automatic t_q24 sat49(input logic signed [48:0] v);
        if (v[48] != v[47]) return v[48] ? MIN48 : MAX48;
        return v[47:0];
    endfunction

    function automatic t_q24 neg_sat(input t_q24 v);
        if (v == MIN48) return MAX48;
        return -v;
    endfunction

    function automatic logic in_bounds(input t_q24 x, input t_q24 y,
                                       input t_q24 sx, input t_q24 sy);
        return (x <= sx) && (y >= sy);
    endfunction

    function automatic t_q24 atan_q24(input logic [4:0] i);
        logic [47:0] one;
        one = 48'd1;
        case (i)
            5'd0:    return 48'sd13176795;
            5'd1:    return 48'sd7778716;
            5'd2:    return 48'sd4110060;
            5'd3:    return 48'sd2086331;
            5'd4:    return 48'sd1047214;
            5'd5:    return 48'sd524117;
            5'd6:    return 48'sd262123;
            5'd7:    return 48'sd131069;
            5'd8:    return 48'sd65536;
            default: return t_q24'(one << (5'd24 - i));
        endcase
    endfunction

endpackage

// File: sv/pde_mul.sv
// Sequential 48x48 signed multiplier, 24x24 partial products, shift and saturate.
// Depends on pde_pkg.
`timescale 1ns / 1ps

module pde_mul import pde_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_q24 i_a,
    input  t_q24 i_b,
    input  logic i_s32,
    output logic o_done,
    output t_q24 o_res
);

    logic [47:0] r_ma, r_mb;
    logic        r_neg, r_s32;
    logic [95:0] r_acc;
    logic [1:0]  r_k;
    logic        r_busy, r_fin, r_done;
    t_q24        r_res;

    logic [23:0] a_d, b_d;
    logic [47:0] pp;
    logic [95:0] pp_sh, p;
    t_q24        n_res;

    always_comb begin
        a_d = r_k[0] ? r_ma[47:24] : r_ma[23:0];
        b_d = r_k[1] ? r_mb[47:24] : r_mb[23:0];
        pp  = 48'(a_d) * 48'(b_d);
        case (r_k)
            2'd0:    pp_sh = {48'd0, pp};
            2'd3:    pp_sh = {pp, 48'd0};
            default: pp_sh = {24'd0, pp, 24'd0};
        endcase
        p = r_s32 ? (r_acc >> 32) : (r_acc >> 24);
        if (r_neg) begin
            n_res = (p > 96'h8000_0000_0000) ? MIN48 : t_q24'(~p[47:0] + 48'd1);
        end else begin
            n_res = (p > 96'h7FFF_FFFF_FFFF) ? MAX48 : t_q24'(p[47:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= mag48(i_a);
            r_mb  <= mag48(i_b);
            r_neg <= i_a[47] != i_b[47];
            r_s32 <= i_s32;
            r_acc <= 96'd0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
        if (r_fin) r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: sv/pde_datapath.sv
// Datapath: flight state, angle reduction, CORDIC, divider and multiplier use.
// Depends on pde_pkg and pde_mul.
`timescale 1ns / 1ps

module pde_datapath import pde_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    input  t_cfg     i_cfg,
    input  t_in      i_in,
    output t_dp_stat o_stat,
    output t_out     o_res
);

    localparam logic [27:0] TWO_PI_U = 28'd105414357;
    localparam logic [24:0] FOLD_C   = 25'd28803371;   // 2^27 - 2*pi

    t_q24        r_speed, r_heading, r_x, r_y;
    logic [63:0] r_time;
    logic        r_flight;

    logic        r_hneg, r_flip;
    logic [47:0] r_msh;
    logic [5:0]  r_cnt;
    t_q24        r_cx, r_cy, r_cz;
    t_q24        r_v2, r_t1, r_t2, r_dv, r_num, r_da, r_dx, r_dy;
    logic [63:0] r_dq;
    logic [47:0] r_drem, r_dvs;

    // multiplier hookup
    t_q24 mul_a, mul_b, mul_res;
    logic mul_s32, mul_done;
    t_q24 dt_q, drag_q, sn, cs;

    assign dt_q   = t_q24'({16'd0, i_cfg.time_step});
    assign drag_q = t_q24'({16'd0, i_cfg.drag_coeff});
    assign sn     = r_cy;
    assign cs     = r_flip ? -r_cx : r_cx;

    always_comb begin
        mul_s32 = 1'b0;
        case (i_cmd.sel)
            MS_V2:   begin mul_a = r_speed;  mul_b = r_speed; end
            MS_GSN:  begin mul_a = GRAV_Q24; mul_b = sn; end
            MS_V2D:  begin mul_a = r_v2;     mul_b = drag_q; mul_s32 = 1'b1; end
            MS_GCS:  begin mul_a = GRAV_Q24; mul_b = cs; end
            MS_VCS:  begin mul_a = r_speed;  mul_b = cs; end
            MS_VSN:  begin mul_a = r_speed;  mul_b = sn; end
            MS_DVDT: begin mul_a = r_dv;     mul_b = dt_q; mul_s32 = 1'b1; end
            MS_DADT: begin mul_a = r_da;     mul_b = dt_q; mul_s32 = 1'b1; end
            MS_DXDT: begin mul_a = r_dx;     mul_b = dt_q; mul_s32 = 1'b1; end
            MS_DYDT: begin mul_a = r_dy;     mul_b = dt_q; mul_s32 = 1'b1; end
            default: begin mul_a = r_dy;     mul_b = dt_q; mul_s32 = 1'b1; end
        endcase
    end

    pde_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == DP_MUL_START),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_s32   (mul_s32),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // each pass trades k*2^27 for k*(2^27 - 2*pi), keeping the value mod 2*pi;
    // twelve passes leave it below 2^28, one subtract then finishes the remainder
    logic [45:0] fold_p;
    logic [47:0] n_msh;
    logic [27:0] fold_lo;
    logic [26:0] rem;
    always_comb begin
        fold_p  = 46'(r_msh[47:27]) * 46'(FOLD_C);
        n_msh   = {2'd0, fold_p} + {21'd0, r_msh[26:0]};
        fold_lo = r_msh[27:0];
        rem     = (fold_lo >= TWO_PI_U) ? 27'(fold_lo - TWO_PI_U) : fold_lo[26:0];
    end

    // wrap into (-pi, pi], then fold into [-pi/2, pi/2]
    t_q24 r0, r1, r2, n_z;
    logic n_flip;
    always_comb begin
        r0 = r_hneg ? -t_q24'({21'd0, rem}) : t_q24'({21'd0, rem});
        r1 = (r0 < 0) ? r0 + TWO_PI_Q24 : r0;
        r2 = (r1 > PI_Q24) ? r1 - TWO_PI_Q24 : r1;
        n_flip = 1'b1;
        if (r2 > HALF_PI_Q24) n_z = PI_Q24 - r2;
        else if (r2 < -HALF_PI_Q24) n_z = -PI_Q24 - r2;
        else begin
            n_z    = r2;
            n_flip = 1'b0;
        end
    end

    t_q24 xs, ys, at;
    always_comb begin
        xs = r_cx >>> r_cnt[4:0];
        ys = r_cy >>> r_cnt[4:0];
        at = atan_q24(r_cnt[4:0]);
    end

    // restoring divider step
    logic [48:0] dtr;
    logic        dge;
    logic [47:0] n_drem;
    always_comb begin
        dtr    = {r_drem, r_dq[63]};
        dge    = dtr >= {1'b0, r_dvs};
        n_drem = dge ? 48'(dtr - {1'b0, r_dvs}) : dtr[47:0];
    end

    t_q24 quot;
    logic qneg;
    always_comb begin
        qneg = r_num[47] != r_speed[47];
        if (r_speed == 48'sd0) begin
            if (r_num > 0) quot = MAX48;
            else if (r_num < 0) quot = MIN48;
            else quot = 48'sd0;
        end else if (qneg) begin
            quot = (r_dq > 64'h8000_0000_0000) ? MIN48 : t_q24'(~r_dq[47:0] + 48'd1);
        end else begin
            quot = (r_dq > 64'h7FFF_FFFF_FFFF) ? MAX48 : t_q24'(r_dq[47:0]);
        end
    end

    logic [47:0] num_mag;
    assign num_mag = mag48(r_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= '0;
            r_heading <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_time    <= '0;
            r_flight  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            case (i_cmd.op)
                DP_LAUNCH: begin
                    r_speed   <= i_in.launch_speed;
                    r_heading <= i_in.launch_angle;
                    r_x       <= i_in.launch_x;
                    r_y       <= i_in.launch_y;
                    r_time    <= '0;
                    r_flight  <= in_bounds(i_in.launch_x, i_in.launch_y,
                                           i_cfg.stop_x, i_cfg.stop_y);
                end
                DP_MOD_INIT: begin
                    r_msh  <= mag48(r_heading);
                    r_hneg <= r_heading[47];
                    r_cnt  <= '0;
                end
                DP_MOD_RUN: begin
                    r_msh <= n_msh;
                    r_cnt <= r_cnt + 6'd1;
                end
                DP_FOLD: begin
                    r_cx   <= CORDIC_GAIN;
                    r_cy   <= '0;
                    r_cz   <= n_z;
                    r_flip <= n_flip;
                    r_cnt  <= '0;
                end
                DP_CORDIC: begin
                    if (!r_cz[47]) begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - at;
                    end else begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + at;
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                DP_MUL_WAIT: begin
                    if (mul_done) begin
                        case (i_cmd.sel)
                            MS_V2:   r_v2  <= mul_res;
                            MS_GSN:  r_t1  <= mul_res;
                            MS_V2D:  r_t2  <= mul_res;
                            MS_GCS:  r_num <= mul_res;
                            MS_VCS:  r_dx  <= mul_res;
                            MS_VSN:  r_dy  <= mul_res;
                            MS_DVDT: r_speed   <= sat49(49'(r_speed) + 49'(mul_res));
                            MS_DADT: r_heading <= sat49(49'(r_heading) + 49'(mul_res));
                            MS_DXDT: r_x <= sat49(49'(r_x) + 49'(mul_res));
                            MS_DYDT: r_y <= sat49(49'(r_y) + 49'(mul_res));
                            default: r_y <= r_y;
                        endcase
                    end
                end
                DP_DRAG_SUM: begin
                    r_dv <= neg_sat(sat49(49'(r_t1) + 49'(r_t2)));
                end
                DP_DIV_START: begin
                    r_dq   <= {num_mag[39:0], 24'd0};
                    r_drem <= '0;
                    r_dvs  <= mag48(r_speed);
                    r_cnt  <= '0;
                end
                DP_DIV_RUN: begin
                    r_drem <= n_drem;
                    r_dq   <= {r_dq[62:0], dge};
                    r_cnt  <= r_cnt + 6'd1;
                end
                DP_DIV_END: begin
                    r_da <= neg_sat(quot);
                end
                DP_FINISH: begin
                    r_time   <= r_time + 64'(i_cfg.time_step);
                    r_flight <= in_bounds(r_x, r_y, i_cfg.stop_x, i_cfg.stop_y);
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_stat = '{
        in_flight:   r_flight,
        mod_last:    r_cnt == 6'd11,
        cordic_last: r_cnt == 6'd23,
        mul_done:    mul_done,
        div_last:    r_cnt == 6'd63
    };

    assign o_res = '{
        elapsed_time: r_time,
        speed:        r_speed,
        heading:      r_heading,
        pos_x:        r_x,
        pos_y:        r_y,
        finished:     !r_flight
    };

endmodule

// File: sv/pde_ctrl.sv
// Controller: loads a launch or sequences one Euler step through the datapath's shared units.
// Depends on pde_pkg.
`timescale 1ns / 1ps

module pde_ctrl import pde_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_opcode,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output logic     o_load,
    output t_dp_cmd  o_cmd
);

    t_state   r_state, n_state;
    t_mul_sel r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= MS_V2;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_cmd.op   = DP_NOP;
        o_cmd.sel  = r_sel;
        o_load     = 1'b0;
        o_in_stall = r_state != S_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_LAUNCH) begin
                        o_cmd.op = DP_LAUNCH;
                        n_state  = S_DONE;
                    end else if (i_stat.in_flight) begin
                        o_cmd.op = DP_MOD_INIT;
                        n_state  = S_MOD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MOD: begin
                o_cmd.op = DP_MOD_RUN;
                if (i_stat.mod_last) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.op = DP_FOLD;
                n_state  = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.op = DP_CORDIC;
                if (i_stat.cordic_last) begin
                    n_sel   = MS_V2;
                    n_state = S_MUL_GO;
                end
            end
            S_MUL_GO: begin
                o_cmd.op = DP_MUL_START;
                n_state  = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                o_cmd.op = DP_MUL_WAIT;
                if (i_stat.mul_done) begin
                    case (r_sel)
                        MS_V2D:  n_state = S_SUM;
                        MS_GCS:  n_state = S_DIV_GO;
                        MS_DYDT: n_state = S_FINISH;
                        default: begin
                            n_sel   = t_mul_sel'(r_sel + 4'd1);
                            n_state = S_MUL_GO;
                        end
                    endcase
                end
            end
            S_SUM: begin
                o_cmd.op = DP_DRAG_SUM;
                n_sel    = MS_GCS;
                n_state  = S_MUL_GO;
            end
            S_DIV_GO: begin
                o_cmd.op = DP_DIV_START;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = DP_DIV_RUN;
                if (i_stat.div_last) n_state = S_DIV_END;
            end
            S_DIV_END: begin
                o_cmd.op = DP_DIV_END;
                n_sel    = MS_VCS;
                n_state  = S_MUL_GO;
            end
            S_FINISH: begin
                o_cmd.op = DP_FINISH;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: sv/projectile_drag_euler_step.sv
// Projectile integrator with quadratic drag, one explicit Euler step per request.
// Launch, or step once finished: goes straight to the done state, where the result is
// registered once the output is free. Step in flight: 12 angle folds, 24 CORDIC iterations,
// 64 divide steps and 10 multiplies, then the result is registered the same way;
// one request at a time, and an output stall holds both the result and the next request.
// Synchronous active-low reset: state zero, not flying, registers at their defaults.
`timescale 1ns / 1ps

module projectile_drag_euler_step import pde_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    // configuration registers, always writable
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step  <= TIME_STEP_RST;
            r_cfg.drag_coeff <= DRAG_RST;
            r_cfg.stop_x     <= STOP_X_RST;
            r_cfg.stop_y     <= STOP_Y_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIME_STEP:  r_cfg.time_step  <= i_cfg_data[31:0];
                CFG_DRAG_COEFF: r_cfg.drag_coeff <= i_cfg_data[31:0];
                CFG_STOP_X:     r_cfg.stop_x     <= i_cfg_data;
                CFG_STOP_Y:     r_cfg.stop_y     <= i_cfg_data;
                default:        r_cfg.stop_y     <= r_cfg.stop_y;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_out     dp_res;
    logic     load;

    // output register: a finished request waits here while the next one is taken
    t_out r_out;
    logic r_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= dp_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    pde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_in_stall (o_in_stall),
        .o_load     (load),
        .o_cmd      (dp_cmd)
    );

    pde_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_cfg   (r_cfg),
        .i_in    (i_in_data),
        .o_stat  (dp_stat),
        .o_res   (dp_res)
    );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for projectile_drag_euler_step: directed table, then random flights.
// Depends on pde_pkg (request/result structs, opcode and register enums) and the RTL top.
`timescale 1ns / 1ps

module tb_top;
    import pde_pkg::*;

    localparam longint Q1       = 64'sd16777216;   // 1.0 in Q23.24
    localparam longint M48      = 64'sh7FFF_FFFF_FFFF;
    localparam longint N48      = -64'sh8000_0000_0000;
    localparam int     WD_LIMIT = 20000;           // cycles without any handshake

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_in         in_req = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_out        o_out_data;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    always #6 i_clk = ~i_clk;

    projectile_drag_euler_step u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ---------------- flight predictor: own copy of registers and state ----------------
    logic [31:0] dt_reg, drag_reg;
    longint      stopx_reg, stopy_reg;
    longint      fl_speed, fl_heading, fl_x, fl_y;
    logic [63:0] fl_time;
    bit          flying;

    t_out expected_points[$];
    int   fails = 0;
    bit   idle_en = 1'b1;

    function automatic longint sat48(longint v);
        if (v > M48) return M48;
        if (v < N48) return N48;
        return v;
    endfunction

    // apply a sign to an unsigned magnitude, saturating to 48 bits
    function automatic longint signed_sat(logic [127:0] m, bit neg);
        if (neg) return (m > 128'h8000_0000_0000) ? N48 : -longint'(m[63:0]);
        return (m > 128'h7FFF_FFFF_FFFF) ? M48 : longint'(m[63:0]);
    endfunction

    function automatic logic [63:0] magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // exact product, magnitude truncated by s bits, saturated
    function automatic longint mul_trunc(longint a, longint b, int s);
        logic [127:0] p;
        p = {64'd0, magn(a)} * {64'd0, magn(b)};
        p = p >> s;
        return signed_sat(p, (a < 0) != (b < 0));
    endfunction

    function automatic void heading_sincos(longint h, output longint sn, output longint cs);
        longint r, x, y, z, at, xs, ys;
        bit     flip;
        r = h % 105414357;
        flip = 1'b0;
        if (r < 0) r += 105414357;
        if (r > 52707179) r -= 105414357;
        if (r > 26353589) begin
            r = 52707179 - r;
            flip = 1'b1;
        end else if (r < -26353589) begin
            r = -52707179 - r;
            flip = 1'b1;
        end
        x = 10188014;
        y = 0;
        z = r;
        for (int i = 0; i < 24; i++) begin
            case (i)
                0: at = 13176795;
                1: at = 7778716;
                2: at = 4110060;
                3: at = 2086331;
                4: at = 1047214;
                5: at = 524117;
                6: at = 262123;
                7: at = 131069;
                8: at = 65536;
                default: at = 64'sd1 <<< (24 - i);
            endcase
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= at;
            end else begin
                x += ys; y -= xs; z += at;
            end
        end
        sn = y;
        cs = flip ? -x : x;
    endfunction

    function automatic bit within_stops();
        return fl_x <= stopx_reg && fl_y >= stopy_reg;
    endfunction

    function automatic void predict_point(t_in rq);
        longint v, sn, cs, v2, dv, num, quot, da, dx, dy;
        logic [63:0] shn, q;
        t_out pt;
        if (rq.opcode == OP_LAUNCH) begin
            fl_speed = rq.launch_speed;
            fl_heading = rq.launch_angle;
            fl_x = rq.launch_x;
            fl_y = rq.launch_y;
            fl_time = '0;
            flying = within_stops();
        end else if (flying) begin
            v = fl_speed;
            heading_sincos(fl_heading, sn, cs);
            v2 = mul_trunc(v, v, 24);
            dv = sat48(-sat48(mul_trunc(GRAV_Q24, sn, 24)
                              + mul_trunc(v2, {32'd0, drag_reg}, 32)));
            num = mul_trunc(GRAV_Q24, cs, 24);
            if (v == 0) begin
                quot = (num > 0) ? M48 : ((num < 0) ? N48 : 0);
            end else begin
                shn = magn(num) << 24;          // top bits drop off, as in 64-bit hardware
                q = shn / magn(v);
                quot = signed_sat({64'd0, q}, (num < 0) != (v < 0));
            end
            da = sat48(-quot);
            dx = mul_trunc(v, cs, 24);
            dy = mul_trunc(v, sn, 24);
            fl_speed = sat48(v + mul_trunc(dv, {32'd0, dt_reg}, 32));
            fl_heading = sat48(fl_heading + mul_trunc(da, {32'd0, dt_reg}, 32));
            fl_x = sat48(fl_x + mul_trunc(dx, {32'd0, dt_reg}, 32));
            fl_y = sat48(fl_y + mul_trunc(dy, {32'd0, dt_reg}, 32));
            fl_time += {32'd0, dt_reg};
            flying = within_stops();
        end
        pt.elapsed_time = fl_time;
        pt.speed = fl_speed[47:0];
        pt.heading = fl_heading[47:0];
        pt.pos_x = fl_x[47:0];
        pt.pos_y = fl_y[47:0];
        pt.finished = !flying;
        expected_points.push_back(pt);
    endfunction

    // ---------------- result checking, stall bursts, watchdog ----------------
    int stall_left = 0;
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        t_out ex;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                fails++;
            end else begin
                ex = expected_points.pop_front();
                if (o_out_data.elapsed_time !== ex.elapsed_time) begin
                    $display("%0t: elapsed_time exp %h got %h", $time,
                             ex.elapsed_time, o_out_data.elapsed_time);
                    fails++;
                end
                if (o_out_data.speed !== ex.speed) begin
                    $display("%0t: speed exp %h got %h", $time, ex.speed, o_out_data.speed);
                    fails++;
                end
                if (o_out_data.heading !== ex.heading) begin
                    $display("%0t: heading exp %h got %h", $time, ex.heading,
                             o_out_data.heading);
                    fails++;
                end
                if (o_out_data.pos_x !== ex.pos_x) begin
                    $display("%0t: pos_x exp %h got %h", $time, ex.pos_x, o_out_data.pos_x);
                    fails++;
                end
                if (o_out_data.pos_y !== ex.pos_y) begin
                    $display("%0t: pos_y exp %h got %h", $time, ex.pos_y, o_out_data.pos_y);
                    fails++;
                end
                if (o_out_data.finished !== ex.finished) begin
                    $display("%0t: finished exp %b got %b", $time, ex.finished,
                             o_out_data.finished);
                    fails++;
                end
            end
        end
        // receiver back-pressure in bursts of random length
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 4);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
        // watchdog: any handshake resets the count
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
            || (cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WD_LIMIT) begin
            $display("projectile_drag_euler_step: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_request(t_in rq);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= rq;
        do @(posedge i_clk); while (o_in_stall);
        predict_point(rq);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TIME_STEP:  dt_reg = val[31:0];
            CFG_DRAG_COEFF: drag_reg = val[31:0];
            CFG_STOP_X:     stopx_reg = longint'(t_q24'(val));
            CFG_STOP_Y:     stopy_reg = longint'(t_q24'(val));
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] dt, logic [31:0] dr, longint sx, longint sy);
        write_reg(CFG_TIME_STEP, {16'd0, dt});
        write_reg(CFG_DRAG_COEFF, {16'd0, dr});
        write_reg(CFG_STOP_X, sx[47:0]);
        write_reg(CFG_STOP_Y, sy[47:0]);
    endtask

    function automatic t_in launch_req(longint v, longint a, longint x, longint y);
        t_in r;
        r.opcode = OP_LAUNCH;
        r.launch_speed = v[47:0];
        r.launch_angle = a[47:0];
        r.launch_x = x[47:0];
        r.launch_y = y[47:0];
        return r;
    endfunction

    function automatic t_in step_req();
        t_in r;
        r = '0;
        r.opcode = OP_STEP;
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return {$urandom, $urandom};
    endfunction

    function automatic t_out point(logic [63:0] t, longint v, longint a, longint x,
                                   longint y, bit fin);
        t_out p;
        p.elapsed_time = t;
        p.speed = v[47:0];
        p.heading = a[47:0];
        p.pos_x = x[47:0];
        p.pos_y = y[47:0];
        p.finished = fin;
        return p;
    endfunction

    // random flights: mostly sensible launches followed by runs of steps, some noise
    task automatic fly_random(int n_items);
        int steps_left;
        t_in rq;
        steps_left = 0;
        for (int k = 0; k < n_items; k++) begin
            if (!flying || steps_left == 0) begin
                if ($urandom_range(0, 4) == 0)
                    rq = launch_req(longint'(t_q24'(rand48())), longint'(t_q24'(rand48())),
                                    longint'(t_q24'(rand48())), longint'(t_q24'(rand48())));
                else
                    rq = launch_req($urandom_range(0, 200) * Q1 + $urandom_range(0, 16777215),
                                    longint'($urandom_range(0, 105414357)) - 52707179,
                                    $urandom_range(0, 100) * Q1,
                                    $urandom_range(0, 100) * Q1);
                steps_left = $urandom_range(3, 40);
                if ($urandom_range(0, 19) == 0) rq.opcode = OP_STEP;   // stray step
            end else begin
                rq = step_req();
                rq.launch_speed = rand48();   // ignored on a step, still wiggled
                steps_left--;
            end
            send_request(rq);
        end
    endtask

    // ---------------- directed table ----------------
    typedef struct {
        t_in  rq;
        bit   has_val;
        t_out val;
    } t_row;

    t_row dir_rows[$];

    task automatic add_row(t_in rq, bit has_val = 0, t_out val = '0);
        t_row r;
        r.rq = rq;
        r.has_val = has_val;
        r.val = val;
        dir_rows.push_back(r);
    endtask

    initial begin
        t_out got;
        // reset values of the predictor's registers
        dt_reg = TIME_STEP_RST;
        drag_reg = DRAG_RST;
        stopx_reg = STOP_X_RST;
        stopy_reg = STOP_Y_RST;
        fl_speed = 0; fl_heading = 0; fl_x = 0; fl_y = 0;
        fl_time = '0;
        flying = 1'b0;

        // step before any launch reports zeros, finished
        add_row(step_req(), 1, point(0, 0, 0, 0, 0, 1));
        add_row(launch_req(50 * Q1, Q1 * 7 / 10, 0, 0), 1, point(0, 50 * Q1, Q1 * 7 / 10, 0, 0, 0));
        add_row(step_req());
        add_row(step_req());
        add_row(step_req());
        // all-max launch lies beyond stop_x: finished at once, steps change nothing
        add_row(launch_req(M48, M48, M48, M48), 1, point(0, M48, M48, M48, M48, 1));
        add_row(step_req(), 1, point(0, M48, M48, M48, M48, 1));
        add_row(launch_req(N48, N48, N48, N48), 1, point(0, N48, N48, N48, N48, 1));
        // zero speed: the heading rate saturates with the sign opposite to cos
        add_row(launch_req(0, 0, 0, 0), 1, point(0, 0, 0, 0, 0, 0));
        add_row(step_req());
        add_row(launch_req(0, 52707179, 0, 10 * Q1));
        add_row(step_req());
        add_row(launch_req(0, 26353589, 0, 10 * Q1));
        add_row(step_req());
        // negative speed, negative heading
        add_row(launch_req(-30 * Q1, -2 * Q1, 5 * Q1, 1000 * Q1));
        add_row(step_req());
        // heading far outside one turn
        add_row(launch_req(100 * Q1, 64'sd1 <<< 46, 0, 10 * Q1));
        add_row(step_req());
        add_row(launch_req(100 * Q1, -(64'sd1 <<< 46), 0, 10 * Q1));
        add_row(step_req());
        // exactly on the stop bounds still flies
        add_row(launch_req(20 * Q1, Q1, STOP_X_RST, 0), 1, point(0, 20 * Q1, Q1, STOP_X_RST, 0, 0));
        add_row(step_req());
        // saturating speed
        add_row(launch_req(M48, 0, 0, 0));
        add_row(step_req());
        add_row(step_req());

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].rq);
            if (dir_rows[i].has_val) begin
                got = expected_points[$];
                if (got !== dir_rows[i].val) begin
                    $display("%0t: row %0d table exp %h predictor %h", $time, i,
                             dir_rows[i].val, got);
                    fails++;
                end
            end
        end

        // extremes: longest step, no drag, bounds wide open
        drain();
        set_regs(32'hFFFF_FFFF, 32'd0, M48, N48);
        fly_random(350);

        // zero step, maximum drag
        drain();
        set_regs(32'd0, 32'hFFFF_FFFF, 1000 * Q1, -1000 * Q1);
        fly_random(250);

        // sensible random setting, with one full pause half way
        drain();
        set_regs($urandom_range(1, 1 << 28), $urandom, $urandom_range(50, 500) * Q1,
                 -longint'($urandom_range(0, 50)) * Q1);
        fly_random(250);
        drain();
        fly_random(250);

        // bounds closed: nothing but the exact corner can fly
        drain();
        set_regs($urandom, $urandom, N48, M48);
        fly_random(150);

        // last stretch without any idling
        drain();
        set_regs($urandom_range(1, 1 << 26), $urandom_range(0, 1 << 24),
                 $urandom_range(20, 300) * Q1, 0);
        idle_en = 1'b0;
        fly_random(625);

        drain();
        repeat (300) @(posedge i_clk);
        if (fails == 0) begin
            $display("projectile_drag_euler_step: match");
        end else begin
            $display("projectile_drag_euler_step: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
sv/pde_pkg.sv
sv/pde_mul.sv
sv/pde_datapath.sv
sv/pde_ctrl.sv
sv/projectile_drag_euler_step.sv
verif/tb_top.sv
